// File: rtl/fwlm_pkg.sv
// ----------------------------------------------------------------------------
// fwlm_pkg: shared definitions for the first window local minimum block
// Sizes, register indexes and the beat types of the sample and result
// channels.
// ----------------------------------------------------------------------------
package fwlm_pkg;

    localparam int MAX_SPAN    = 7;
    localparam int SAMPLE_BITS = 32;
    localparam int MAX_ITEMS   = 131071;

    localparam int HIST_DEPTH = 2 * MAX_SPAN + 1;
    localparam int CAND_NUM   = MAX_SPAN + 1;
    localparam int SPAN_BITS  = 3;
    localparam int CNT_BITS   = $clog2(MAX_ITEMS + 1);
    localparam int POS_BITS   = 17;
    localparam int SEL_BITS   = $clog2(CAND_NUM);
    localparam int IDX_BITS   = 1;

    // Configuration register indexes.
    localparam logic [IDX_BITS-1:0] REG_BACK_SPAN  = 1'b0;
    localparam logic [IDX_BITS-1:0] REG_AHEAD_SPAN = 1'b1;

    typedef logic [SAMPLE_BITS-1:0]               sample_t;
    typedef logic [CAND_NUM-1:0][SAMPLE_BITS-1:0] cand_vec_t;
    typedef logic [HIST_DEPTH-1:0][CAND_NUM-1:0]  ge_mat_t;
    typedef logic [SPAN_BITS-1:0]                 span_t;
    typedef logic [CNT_BITS-1:0]                  count_t;

    typedef struct packed {
        logic [31:0] sample;
        logic        last;
    } sample_beat_t;

    typedef struct packed {
        logic                found;
        logic [POS_BITS-1:0] position;
    } result_beat_t;

    // Verdict of the judge for the item in the evaluation stage.
    typedef struct packed {
        logic                emit;
        logic                found;
        logic [POS_BITS-1:0] position;
    } verdict_t;

endpackage

// File: rtl/fwlm_cell.sv
// ----------------------------------------------------------------------------
// fwlm_cell: one history cell
// Holds one stored sample, passes it to the next cell on a shift and
// compares it against every candidate sample.
// ----------------------------------------------------------------------------
module fwlm_cell
    import fwlm_pkg::*;
(
    input  logic                clk,
    input  logic                shift_en,
    input  sample_t             shift_in,
    input  cand_vec_t           cand,
    output sample_t             value,
    output logic [CAND_NUM-1:0] ge
);

    sample_t value_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            value_reg <= shift_in;
        end
    end

    // A cell never disqualifies a candidate that is not larger than it.
    always_comb
    begin
        for (int c = 0; c < CAND_NUM; c++)
        begin
            ge[c] = (value_reg >= cand[c]);
        end
    end

    assign value = value_reg;

endmodule

// File: rtl/fwlm_judge.sv
// ----------------------------------------------------------------------------
// fwlm_judge: candidate judge
// Combines the cell comparisons into a verdict for the candidate ahead_span
// places back, or for all trailing candidates when the stream ends.
// ----------------------------------------------------------------------------
module fwlm_judge
    import fwlm_pkg::*;
(
    input  ge_mat_t  ge,
    input  count_t   count,
    input  span_t    back_span,
    input  span_t    ahead_span,
    input  logic     last,
    input  logic     answered,
    output verdict_t verdict
);

    logic [CAND_NUM-1:0] qual;
    logic [SEL_BITS-1:0] ya;
    logic [SEL_BITS-1:0] sel;
    logic                any;

    // Candidate k sits k places back; its window runs from the newest sample
    // to k + back_span places back, cut at the start of the stream.
    always_comb
    begin
        for (int k = 0; k < CAND_NUM; k++)
        begin
            qual[k] = (int'(count) > k);
            for (int m = 0; m < HIST_DEPTH; m++)
            begin
                if ((m <= k + int'(back_span)) && (int'(count) > m) && !ge[m][k])
                begin
                    qual[k] = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        ya = (int'(ahead_span) > MAX_SPAN) ? SEL_BITS'(MAX_SPAN) : SEL_BITS'(ahead_span);
        sel = '0;
        any = 1'b0;
        // Ascending scan leaves the oldest qualifying candidate selected.
        for (int k = 0; k < CAND_NUM; k++)
        begin
            if ((k <= int'(ya)) && qual[k])
            begin
                any = 1'b1;
                sel = SEL_BITS'(k);
            end
        end

        if (last)
        begin
            verdict.emit     = !answered;
            verdict.found    = any;
            verdict.position = any ? POS_BITS'(count - CNT_BITS'(sel)) : '0;
        end
        else
        begin
            verdict.emit     = !answered && (count > CNT_BITS'(ya)) && qual[ya];
            verdict.found    = 1'b1;
            verdict.position = POS_BITS'(count - CNT_BITS'(ya));
        end
    end

endmodule

// File: rtl/first_window_local_minimum_top.sv
// ----------------------------------------------------------------------------
// first_window_local_minimum_top: streaming local minimum finder
// Reports the first sample of a stream that is not larger than any sample in
// its surrounding window, or a not-found beat at the end of the stream.
// ----------------------------------------------------------------------------
// The block takes one sample beat per cycle unless stalled and answers after
// the beat that settles the answer: a sample is confirmed when the sample
// ahead_span places later arrives, and the trailing samples are judged on
// the beat marked last, so each stream yields at most one result beat. The
// samples live in a row of fifteen cells that shift on every accepted beat
// until the stream holds MAX_ITEMS samples; each cell compares its own value
// against the eight newest samples, and a judge stage ANDs those comparisons
// over each candidate's window. A result passes the judge stage and then the
// output register. Back-pressure on the result channel only stalls the
// sample channel when a result is waiting in the output register and another
// result is ready behind it. The history clears lazily: the first beat of a
// new stream restarts the count, and samples older than the count are never
// looked at. Streams longer than MAX_ITEMS keep their first MAX_ITEMS
// samples. The user must write back_span and ahead_span through the
// configuration port only while the block is idle, which is not enforced.
// ----------------------------------------------------------------------------
module first_window_local_minimum_top
    import fwlm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                sample_valid,
    output logic                sample_stall,
    input  sample_beat_t        sample_beat,

    output logic                result_valid,
    input  logic                result_stall,
    output result_beat_t        result_beat,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [IDX_BITS-1:0] cfg_index,
    input  logic [SPAN_BITS-1:0] cfg_data
);

    // Configuration registers.
    span_t back_span_reg;
    span_t ahead_span_reg;

    // Stream bookkeeping.
    count_t count_reg;
    count_t count_next;
    logic   restart_reg;
    logic   answered_reg;
    logic   answered_next;

    // Evaluation stage.
    logic   eval_valid_reg;
    logic   eval_last_reg;

    // Output register.
    logic         result_valid_reg;
    result_beat_t result_beat_reg;

    logic      accept;
    logic      advance;
    logic      shift_en;
    count_t    count_base;
    verdict_t  verdict;
    cand_vec_t cand;
    ge_mat_t   ge;
    sample_t   chain [HIST_DEPTH];
    sample_t   chain_in [HIST_DEPTH];

    assign cfg_ready = 1'b1;

    // The evaluation stage moves on unless it holds a result while the output
    // register is full and stalled.
    assign advance = !eval_valid_reg || !verdict.emit || !result_valid_reg || !result_stall;
    assign sample_stall = !advance;
    assign accept = sample_valid && advance;

    // A new stream starts counting from zero; a full stream stops shifting.
    assign count_base = restart_reg ? '0 : count_reg;
    assign shift_en   = accept && (count_base < CNT_BITS'(MAX_ITEMS));
    assign count_next = shift_en ? count_base + 1'b1 : count_base;

    // Cell chain: cell 0 takes the new sample, each other cell its neighbor.
    genvar g;
    generate
        for (g = 0; g < HIST_DEPTH; g++)
        begin : g_cell
            if (g == 0)
            begin : g_head
                assign chain_in[g] = sample_t'(sample_beat.sample);
            end
            else
            begin : g_link
                assign chain_in[g] = chain[g-1];
            end

            fwlm_cell u_cell (
                .clk      (clk),
                .shift_en (shift_en),
                .shift_in (chain_in[g]),
                .cand     (cand),
                .value    (chain[g]),
                .ge       (ge[g])
            );
        end
    endgenerate

    always_comb
    begin
        for (int c = 0; c < CAND_NUM; c++)
        begin
            cand[c] = chain[c];
        end
    end

    fwlm_judge u_judge (
        .ge         (ge),
        .count      (count_reg),
        .back_span  (back_span_reg),
        .ahead_span (ahead_span_reg),
        .last       (eval_last_reg),
        .answered   (answered_reg),
        .verdict    (verdict)
    );

    // A stream is answered after its first result; its last beat reopens it.
    always_comb
    begin
        answered_next = answered_reg;
        if (eval_valid_reg && advance)
        begin
            if (eval_last_reg)
            begin
                answered_next = 1'b0;
            end
            else if (verdict.emit)
            begin
                answered_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            back_span_reg    <= '0;
            ahead_span_reg   <= '0;
            count_reg        <= '0;
            restart_reg      <= 1'b0;
            answered_reg     <= 1'b0;
            eval_valid_reg   <= 1'b0;
            eval_last_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_BACK_SPAN:  back_span_reg  <= cfg_data;
                    REG_AHEAD_SPAN: ahead_span_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (accept)
            begin
                count_reg   <= count_next;
                restart_reg <= sample_beat.last;
            end
            answered_reg <= answered_next;

            if (advance)
            begin
                eval_valid_reg <= sample_valid;
                eval_last_reg  <= sample_beat.last;
            end

            if (eval_valid_reg && verdict.emit && advance)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (eval_valid_reg && verdict.emit && advance)
        begin
            result_beat_reg.found    <= verdict.found;
            result_beat_reg.position <= verdict.position;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_beat  = result_beat_reg;

    // Every accepted sample is judged in the next cycle.
    a_accept_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> eval_valid_reg)
        else $error("accepted sample did not reach the judge stage");

    // The judge only ever sees a stream that holds samples.
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        eval_valid_reg |-> (count_reg != '0))
        else $error("judge stage active with an empty stream");

    // A not-found result is only given on the last beat of a stream.
    a_notfound_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (eval_valid_reg && verdict.emit && !verdict.found) |-> eval_last_reg)
        else $error("not-found result before the end of the stream");

    // An answered stream gives no further results.
    a_single_answer: assert property (@(posedge clk) disable iff (!rst_n)
        (eval_valid_reg && answered_reg) |-> !verdict.emit)
        else $error("second result within one stream");

endmodule
